// ===== rtl/core/axis_deadzone_saturation_scaler_unit_assert.svh =====
// Assertion macros used by the axis scaler back end.
`ifndef AXIS_DEADZONE_SATURATION_SCALER_UNIT_ASSERT_SVH
`define AXIS_DEADZONE_SATURATION_SCALER_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define ADSS_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("adss assertion failed");

// Condition holds in the cycle after the trigger.
`define ADSS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("adss assertion failed");

`endif

// ===== rtl/core/adss_pkg.sv =====
// Package: types, constants and register codes of the axis scaler.
`default_nettype none
package adss_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned DIV_STEPS   = 48;
    localparam int unsigned CNT_W       = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_CUT_POS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_CUT_NEG = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_CUT_POS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_CUT_NEG  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_NEUTRAL  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE = 4'd7;

    typedef enum logic [1:0] {
        K_NEUTRAL,
        K_MAX,
        K_MIN,
        K_MAP
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM
    } t_state;

    // Classified sample: for a mapped sample, displacement and band width
    // are both positive magnitudes.
    typedef struct packed {
        t_kind       kind;
        logic        side_neg;
        logic [15:0] disp;
        logic [15:0] span_in;
    } t_item;

    typedef struct packed {
        logic [14:0]        dead_cut_pos;
        logic signed [15:0] dead_cut_neg;
        logic [14:0]        sat_cut_pos;
        logic signed [15:0] sat_cut_neg;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic signed [31:0] out_neutral;
        logic               event_enable;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/core/adss_if.sv =====
// Channel interfaces: sample input, result output and register write.
`default_nettype none
interface adss_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface adss_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] scaled_value;
    logic               value_changed;
    logic               event_raised;

    modport source (output valid, output scaled_value, output value_changed,
                    output event_raised, input ready);
    modport sink   (input valid, input scaled_value, input value_changed,
                    input event_raised, output ready);
endinterface

interface adss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [adss_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [31:0]                       reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/adss_front.sv =====
// Front end: accept samples, classify them against the cutoffs, register the result.
`default_nettype none
module adss_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire adss_pkg::t_cfg i_cfg,
    adss_sample_if.sink         i_sample,
    output logic                o_item_valid,
    output adss_pkg::t_item     o_item,
    input  wire logic           i_item_ready
);

    logic            r_valid;
    adss_pkg::t_item r_item;
    adss_pkg::t_item n_item;

    logic signed [16:0] x;
    logic signed [16:0] dcp;
    logic signed [16:0] dcn;
    logic signed [16:0] scp;
    logic signed [16:0] scn;
    logic signed [16:0] disp_pos;
    logic signed [16:0] disp_neg;
    logic signed [16:0] span_pos;
    logic signed [16:0] span_neg;

    assign x   = 17'(i_sample.raw_sample);
    assign dcp = $signed({2'b00, i_cfg.dead_cut_pos});
    assign scp = $signed({2'b00, i_cfg.sat_cut_pos});
    assign dcn = 17'(i_cfg.dead_cut_neg);
    assign scn = 17'(i_cfg.sat_cut_neg);

    assign disp_pos = x - dcp;
    assign span_pos = scp - dcp;
    assign disp_neg = dcn - x;
    assign span_neg = dcn - scn;

    // Zero goes with the negative side; it lands in the deadzone when the negative deadzone cutoff is not above zero.
    always_comb begin
        n_item.side_neg = (x <= 17'sd0);
        n_item.disp     = n_item.side_neg ? disp_neg[15:0] : disp_pos[15:0];
        n_item.span_in  = n_item.side_neg ? span_neg[15:0] : span_pos[15:0];
        if (!n_item.side_neg) begin
            if (x <= dcp)      n_item.kind = adss_pkg::K_NEUTRAL;
            else if (x >= scp) n_item.kind = adss_pkg::K_MAX;
            else               n_item.kind = adss_pkg::K_MAP;
        end else begin
            if (x >= dcn)      n_item.kind = adss_pkg::K_NEUTRAL;
            else if (x <= scn) n_item.kind = adss_pkg::K_MIN;
            else               n_item.kind = adss_pkg::K_MAP;
        end
    end

    assign i_sample.ready = !r_valid || i_item_ready;
    assign o_item_valid   = r_valid;
    assign o_item         = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/adss_queue.sv =====
// Short FIFO of classified samples between front end and back end.
`default_nettype none
module adss_queue #(
    parameter int unsigned DEPTH = adss_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    input  wire adss_pkg::t_item i_push_item,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output adss_pkg::t_item      o_pop_item,
    input  wire logic            i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    adss_pkg::t_item mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= wrap_inc(r_wr_ptr);
            if (pop)  r_rd_ptr <= wrap_inc(r_rd_ptr);
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/adss_back.sv =====
// Back end: multiply, bit-serial divide, offset, change tracking and result register.
`default_nettype none
`include "axis_deadzone_saturation_scaler_unit_assert.svh"
module adss_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire adss_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_valid,
    input  wire adss_pkg::t_item i_q_item,
    output logic                 o_q_pop,
    adss_result_if.source        o_result
);

    adss_pkg::t_state r_state;
    adss_pkg::t_state n_state;

    logic [15:0]                  r_disp;
    logic [15:0]                  r_div;
    logic [32:0]                  r_span_mag;
    logic                         r_neg;
    logic [47:0]                  r_quo;
    logic [15:0]                  r_rem;
    logic [adss_pkg::CNT_W-1:0]   r_cnt;

    logic                         r_out_valid;
    logic [31:0]                  r_value;
    logic                         r_changed;
    logic                         r_event;
    logic [31:0]                  r_last;

    logic        out_free;
    logic        load_map;
    logic        produce;
    logic [31:0] y;
    logic [32:0] span_out;
    logic [48:0] product;
    logic [16:0] trial;
    logic        trial_ge;
    logic [31:0] q_signed;

    assign out_free = !r_out_valid || o_result.ready;

    assign span_out = i_q_item.side_neg
                    ? (33'(i_cfg.out_min) - 33'(i_cfg.out_neutral))
                    : (33'(i_cfg.out_max) - 33'(i_cfg.out_neutral));
    assign product  = 49'(r_disp) * 49'(r_span_mag);
    assign trial    = {r_rem, r_quo[47]};
    assign trial_ge = (trial >= {1'b0, r_div});
    assign q_signed = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            adss_pkg::ST_IDLE: begin
                if (i_q_valid && (i_q_item.kind == adss_pkg::K_MAP)) n_state = adss_pkg::ST_MUL;
            end
            adss_pkg::ST_MUL: n_state = adss_pkg::ST_DIV;
            adss_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = adss_pkg::ST_SUM;
            end
            adss_pkg::ST_SUM: begin
                if (out_free) n_state = adss_pkg::ST_IDLE;
            end
            default: n_state = adss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        load_map = 1'b0;
        produce  = 1'b0;
        y        = i_cfg.out_neutral;
        unique case (r_state)
            adss_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.kind)
                        adss_pkg::K_MAP: begin
                            o_q_pop  = 1'b1;
                            load_map = 1'b1;
                        end
                        adss_pkg::K_MAX: begin
                            o_q_pop = out_free;
                            produce = out_free;
                            y       = i_cfg.out_max;
                        end
                        adss_pkg::K_MIN: begin
                            o_q_pop = out_free;
                            produce = out_free;
                            y       = i_cfg.out_min;
                        end
                        default: begin
                            o_q_pop = out_free;
                            produce = out_free;
                        end
                    endcase
                end
            end
            adss_pkg::ST_SUM: begin
                produce = out_free;
                y       = i_cfg.out_neutral + q_signed;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sign-magnitude datapath: quotient of magnitudes truncates toward zero.
    always_ff @(posedge i_clk) begin
        if (load_map) begin
            r_disp     <= i_q_item.disp;
            r_div      <= i_q_item.span_in;
            r_neg      <= span_out[32];
            r_span_mag <= span_out[32] ? (33'd0 - span_out) : span_out;
        end
        if (r_state == adss_pkg::ST_MUL) begin
            r_quo <= product[47:0];
            r_rem <= '0;
            r_cnt <= adss_pkg::CNT_W'(adss_pkg::DIV_STEPS - 1);
        end
        if (r_state == adss_pkg::ST_DIV) begin
            r_quo <= {r_quo[46:0], trial_ge};
            r_rem <= trial_ge ? 16'(trial - {1'b0, r_div}) : trial[15:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else if (produce) begin
            r_out_valid <= 1'b1;
            r_last      <= y;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_value   <= y;
            r_changed <= (y != r_last);
            r_event   <= (y != r_last) && i_cfg.event_enable;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.scaled_value  = r_value;
    assign o_result.value_changed = r_changed;
    assign o_result.event_raised  = r_event;

    `ADSS_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == adss_pkg::ST_DIV, r_div != '0)
    `ADSS_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_state == adss_pkg::ST_DIV, r_rem < r_div)
    `ADSS_ASSERT_NOW(a_quo_fits, i_clk, i_rst_n, r_state == adss_pkg::ST_SUM, r_quo[47:33] == '0)
    `ADSS_ASSERT_NEXT(a_last_tracks, i_clk, i_rst_n, produce, r_last == r_value)

endmodule
`default_nettype wire

// ===== rtl/core/axis_deadzone_saturation_scaler_unit.sv =====
// Top level of the axis deadzone, saturation and range scaler.
//
//  channel   dir  handshake    payload
//  i_sample  in   valid/ready  raw_sample[15:0] signed
//  o_result  out  valid/ready  scaled_value[31:0] signed, value_changed, event_raised
//  i_cfg     in   valid/ready  reg_index[3:0], reg_data[31:0]; ready always high
//
// A deadzone or saturated sample passes through the front-end register, the queue and
// the output register. A sample in the mapped band also runs the MUL, DIV and SUM states,
// with the 48-step one-bit-per-cycle divider; the back end handles one sample at a time.
// The front end and a two-entry queue keep taking samples while the back end works.
// Reset is synchronous and active low; it loads the register defaults and clears
// the last value. A stalled result holds in the output register and backs up the queue.
`default_nettype none
module axis_deadzone_saturation_scaler_unit #(
    parameter int unsigned QUEUE_DEPTH = adss_pkg::QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    adss_sample_if.sink   i_sample,
    adss_result_if.source o_result,
    adss_cfg_if.sink      i_cfg
);

    adss_pkg::t_cfg  r_cfg;
    logic            front_valid;
    adss_pkg::t_item front_item;
    logic            front_ready;
    logic            q_valid;
    adss_pkg::t_item q_item;
    logic            q_pop;

    assign i_cfg.ready = 1'b1;

    // Writes past the register list drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_cut_pos <= 15'd0;
            r_cfg.dead_cut_neg <= 16'sd0;
            r_cfg.sat_cut_pos  <= 15'd32767;
            r_cfg.sat_cut_neg  <= -16'sd32768;
            r_cfg.out_min      <= -32'sd32768;
            r_cfg.out_max      <= 32'sd32767;
            r_cfg.out_neutral  <= 32'sd0;
            r_cfg.event_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                adss_pkg::REG_DEAD_CUT_POS: r_cfg.dead_cut_pos <= i_cfg.reg_data[14:0];
                adss_pkg::REG_DEAD_CUT_NEG: r_cfg.dead_cut_neg <= i_cfg.reg_data[15:0];
                adss_pkg::REG_SAT_CUT_POS:  r_cfg.sat_cut_pos  <= i_cfg.reg_data[14:0];
                adss_pkg::REG_SAT_CUT_NEG:  r_cfg.sat_cut_neg  <= i_cfg.reg_data[15:0];
                adss_pkg::REG_OUT_MIN:      r_cfg.out_min      <= i_cfg.reg_data;
                adss_pkg::REG_OUT_MAX:      r_cfg.out_max      <= i_cfg.reg_data;
                adss_pkg::REG_OUT_NEUTRAL:  r_cfg.out_neutral  <= i_cfg.reg_data;
                adss_pkg::REG_EVENT_ENABLE: r_cfg.event_enable <= i_cfg.reg_data[0];
                default: ;
            endcase
        end
    end

    adss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_sample     (i_sample),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (front_ready)
    );

    adss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_item   (q_item),
        .i_pop        (q_pop)
    );

    adss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire
